@@ rtl/hdrenc_pkg.sv @@
// Shared types and constants for the header text Q/B encoder.
`timescale 1ns / 1ps

package hdrenc_pkg;

    // Input beat: one raw header byte and its end-of-text flag
    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } in_beat_t;

    // Output beat: one encoded character and its end-of-text flag
    typedef struct packed {
        logic [6:0] out_char;
        logic       last_char;
    } out_beat_t;

    // Work classes handed from front to back
    typedef enum logic [2:0] {
        OP_CRLF      = 3'd0,  // CR LF line break, passed through
        OP_Q_BYTE    = 3'd1,  // one byte, Q rules
        OP_Q_CR_BYTE = 3'd2,  // held CR as "=0D", then one byte by Q rules
        OP_B_FULL    = 3'd3,  // full three-byte group
        OP_B_ONE     = 3'd4,  // final group of one byte, two pads
        OP_B_TWO     = 3'd5   // final group of two bytes, one pad
    } op_t;

    // One queue entry: class, group bytes (Q uses the low byte), end flag
    typedef struct packed {
        op_t         op;
        logic [23:0] group;
        logic        last;
    } work_t;

    localparam logic       MODE_Q = 1'b0;
    localparam logic       MODE_B = 1'b1;

    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_EQUALS     = 8'h3D;
    localparam logic [7:0] CH_DEL        = 8'h7F;

endpackage

@@ rtl/hdrenc_front.sv @@
// Front end: accepts input beats, tracks CR lookahead and base64 grouping.
`timescale 1ns / 1ps

module hdrenc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                in_valid,
    input  hdrenc_pkg::in_beat_t in_data,
    input  logic                queue_full,
    output logic                in_stall,
    output logic                push,
    output hdrenc_pkg::work_t   push_data
);

    logic        mode_reg;
    logic        pending_cr_reg;
    logic        pending_cr_next;
    logic [15:0] held_bytes_reg;
    logic [15:0] held_bytes_next;
    logic [1:0]  held_count_reg;
    logic [1:0]  held_count_next;
    logic        accept;
    logic        emit;
    logic [1:0]  cnt;
    logic [7:0]  b;
    logic        last;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign push     = accept && emit;
    assign b        = in_data.in_byte;
    assign last     = in_data.last_byte;
    assign cnt      = held_count_reg + 2'd1;

    // Classify the beat and compute the next front state
    always_comb
    begin
        pending_cr_next = pending_cr_reg;
        held_bytes_next = held_bytes_reg;
        held_count_next = held_count_reg;
        emit            = 1'b0;
        push_data.op    = hdrenc_pkg::OP_Q_BYTE;
        push_data.group = {held_bytes_reg, b};
        push_data.last  = last;

        if (mode_reg == hdrenc_pkg::MODE_Q)
        begin
            if (pending_cr_reg && b == hdrenc_pkg::CH_LF)
            begin
                emit            = 1'b1;
                push_data.op    = hdrenc_pkg::OP_CRLF;
                pending_cr_next = 1'b0;
            end
            else if (pending_cr_reg)
            begin
                emit = 1'b1;
                if (b == hdrenc_pkg::CH_CR && !last)
                begin
                    // held CR goes out quoted, new CR is held in its place
                    push_data.op    = hdrenc_pkg::OP_Q_BYTE;
                    pending_cr_next = 1'b1;
                end
                else
                begin
                    push_data.op    = hdrenc_pkg::OP_Q_CR_BYTE;
                    pending_cr_next = 1'b0;
                end
            end
            else if (b == hdrenc_pkg::CH_CR && !last)
            begin
                pending_cr_next = 1'b1;
            end
            else
            begin
                emit         = 1'b1;
                push_data.op = hdrenc_pkg::OP_Q_BYTE;
            end
        end
        else
        begin
            if (cnt == 2'd3)
            begin
                emit            = 1'b1;
                push_data.op    = hdrenc_pkg::OP_B_FULL;
                held_bytes_next = '0;
                held_count_next = '0;
            end
            else if (last)
            begin
                emit         = 1'b1;
                push_data.op = (cnt == 2'd1) ? hdrenc_pkg::OP_B_ONE : hdrenc_pkg::OP_B_TWO;
            end
            else
            begin
                held_bytes_next = push_data.group[15:0];
                held_count_next = cnt;
            end
        end

        // end of text starts a fresh one
        if (last)
        begin
            pending_cr_next = 1'b0;
            held_bytes_next = '0;
            held_count_next = '0;
        end
    end

    // Mode register and front state; a mode write drops any partial text
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= hdrenc_pkg::MODE_Q;
            pending_cr_reg <= 1'b0;
            held_bytes_reg <= '0;
            held_count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            mode_reg       <= cfg_wr_data;
            pending_cr_reg <= 1'b0;
            held_bytes_reg <= '0;
            held_count_reg <= '0;
        end
        else if (accept)
        begin
            pending_cr_reg <= pending_cr_next;
            held_bytes_reg <= held_bytes_next;
            held_count_reg <= held_count_next;
        end
    end

    a_cr_only_in_q: assert property (@(posedge clk) disable iff (!rst_n)
        pending_cr_reg |-> (mode_reg == hdrenc_pkg::MODE_Q))
        else $error("CR held outside Q mode");

    a_group_only_in_b: assert property (@(posedge clk) disable iff (!rst_n)
        (held_count_reg != 2'd0) |-> (mode_reg == hdrenc_pkg::MODE_B))
        else $error("bytes held outside B mode");

endmodule

@@ rtl/hdrenc_queue.sv @@
// Small FIFO of work entries between the front and back ends.
`timescale 1ns / 1ps

module hdrenc_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hdrenc_pkg::work_t push_data,
    input  logic              pop,
    output logic              full,
    output logic              head_valid,
    output hdrenc_pkg::work_t head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    hdrenc_pkg::work_t    entry_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

@@ rtl/hdrenc_back.sv @@
// Back end: turns work entries into encoded chars, one per unstalled cycle.
`timescale 1ns / 1ps

module hdrenc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  hdrenc_pkg::work_t     head_data,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output hdrenc_pkg::out_beat_t out_data
);

    // Base64 alphabet lookup
    function automatic logic [6:0] b64_char(input logic [5:0] i);
        logic [6:0] c;
        if (i < 6'd26)
            c = 7'h41 + {1'b0, i};
        else if (i < 6'd52)
            c = 7'h61 + {1'b0, i} - 7'd26;
        else if (i < 6'd62)
            c = 7'h30 + {1'b0, i} - 7'd52;
        else if (i == 6'd62)
            c = 7'h2B;
        else
            c = 7'h2F;
        return c;
    endfunction

    // Uppercase hex digit
    function automatic logic [6:0] hex_char(input logic [3:0] n);
        logic [6:0] c;
        if (n < 4'd10)
            c = 7'h30 + {3'b000, n};
        else
            c = 7'h41 + {3'b000, n} - 7'd10;
        return c;
    endfunction

    // 8-bit, control, underscore and especial bytes get "=XX"
    function automatic logic needs_quote(input logic [7:0] v);
        logic q;
        q = v[7] || (v < 8'h20) || (v == hdrenc_pkg::CH_DEL)
            || (v == hdrenc_pkg::CH_UNDERSCORE);
        case (v) inside
            "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
            "/", "[", "]", "?", ".", "=": q = 1'b1;
            default: ;
        endcase
        return q;
    endfunction

    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic [2:0] len;
    logic [6:0] chars [6];
    logic [6:0] q_c0;
    logic [6:0] q_c1;
    logic [6:0] q_c2;
    logic [2:0] q_len;
    logic [7:0] qb;
    logic [23:0] g;
    logic       load;
    logic       at_end;
    logic       out_valid_reg;
    hdrenc_pkg::out_beat_t out_data_reg;

    assign g  = head_data.group;
    assign qb = g[7:0];

    // Q expansion of one byte
    always_comb
    begin
        q_c0  = qb[6:0];
        q_c1  = hdrenc_pkg::CH_EQUALS[6:0];
        q_c2  = hdrenc_pkg::CH_EQUALS[6:0];
        q_len = 3'd1;
        if (qb == hdrenc_pkg::CH_SPACE)
        begin
            q_c0 = hdrenc_pkg::CH_UNDERSCORE[6:0];
        end
        else if (needs_quote(qb))
        begin
            q_c0  = hdrenc_pkg::CH_EQUALS[6:0];
            q_c1  = hex_char(qb[7:4]);
            q_c2  = hex_char(qb[3:0]);
            q_len = 3'd3;
        end
    end

    // Character list of the head entry
    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            chars[k] = hdrenc_pkg::CH_EQUALS[6:0];
        end
        len = 3'd4;
        unique case (head_data.op)
            hdrenc_pkg::OP_CRLF:
            begin
                chars[0] = hdrenc_pkg::CH_CR[6:0];
                chars[1] = hdrenc_pkg::CH_LF[6:0];
                len      = 3'd2;
            end
            hdrenc_pkg::OP_Q_BYTE:
            begin
                chars[0] = q_c0;
                chars[1] = q_c1;
                chars[2] = q_c2;
                len      = q_len;
            end
            hdrenc_pkg::OP_Q_CR_BYTE:
            begin
                chars[0] = hdrenc_pkg::CH_EQUALS[6:0];
                chars[1] = hex_char(hdrenc_pkg::CH_CR[7:4]);
                chars[2] = hex_char(hdrenc_pkg::CH_CR[3:0]);
                chars[3] = q_c0;
                chars[4] = q_c1;
                chars[5] = q_c2;
                len      = 3'd3 + q_len;
            end
            hdrenc_pkg::OP_B_FULL:
            begin
                chars[0] = b64_char(g[23:18]);
                chars[1] = b64_char(g[17:12]);
                chars[2] = b64_char(g[11:6]);
                chars[3] = b64_char(g[5:0]);
            end
            hdrenc_pkg::OP_B_ONE:
            begin
                chars[0] = b64_char(g[7:2]);
                chars[1] = b64_char({g[1:0], 4'b0000});
            end
            hdrenc_pkg::OP_B_TWO:
            begin
                chars[0] = b64_char(g[15:10]);
                chars[1] = b64_char(g[9:4]);
                chars[2] = b64_char({g[3:0], 2'b00});
            end
            default:
            begin
                len = 3'd1;
            end
        endcase
    end

    // Step through the entry as the output register frees up
    assign load     = head_valid && (!out_valid_reg || !out_stall);
    assign at_end   = (idx_reg == len - 3'd1);
    assign pop      = load && at_end;
    assign idx_next = at_end ? 3'd0 : idx_reg + 3'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                idx_reg       <= idx_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg.out_char  <= chars[idx_reg];
            out_data_reg.last_char <= head_data.last && at_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (idx_reg < len))
        else $error("character index past end of entry");

    a_entry_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != 3'd0) |-> head_valid)
        else $error("entry vanished mid-expansion");

endmodule

@@ rtl/header_text_q_b_encoder_unit.sv @@
// Top level of the header text Q/B encoder.
`timescale 1ns / 1ps

// Header text encoder: raw header bytes in, Q or base64 encoded text out.
// Input channel in_valid/in_stall/in_data carries one byte per beat with
// last_byte on the final byte of a text. Output channel
// out_valid/out_stall/out_data carries one character per beat, last_char
// set on the final character of the text.
// cfg_wr_en/cfg_wr_data writes the mode (0 = Q, 1 = B); a write drops any
// partly received text. Write only while the block is idle.
// A byte's first character passes through the work queue and the output
// register before it is valid on out_data.
// Throughput: the output side emits one character per cycle unless stalled,
// and a byte yields 0 to 6 characters (Q: 0 for a held CR, 1 plain, 3 quoted,
// 2 for CR LF, up to 6 for a held CR flushed ahead of a quoted byte; B: 4 per
// 3-byte group or padded final group, 0 for a byte that leaves its group open).
// The front end takes one byte per cycle until the QUEUE_DEPTH-entry work
// queue fills; the back-end character sequencer sets the sustained rate.
// Reset clears the mode to Q, all lookahead and group state and the queue.
// A stalled output holds its beat; backpressure reaches in_stall only once
// the queue is full.

module header_text_q_b_encoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  hdrenc_pkg::in_beat_t  in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output hdrenc_pkg::out_beat_t out_data
);

    logic              push;
    logic              pop;
    logic              queue_full;
    logic              head_valid;
    hdrenc_pkg::work_t push_data;
    hdrenc_pkg::work_t head_data;

    hdrenc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_data     (in_data),
        .queue_full  (queue_full),
        .in_stall    (in_stall),
        .push        (push),
        .push_data   (push_data)
    );

    hdrenc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    hdrenc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule
